[hw/rtl/csl_pkg.sv]
`default_nettype none
package csl_pkg;

   // default widths of the top level parameters
   localparam int DEF_POSITION_WIDTH = 16;
   localparam int DEF_VALUE_WIDTH    = 32;

   // fixed field widths of a result transaction
   localparam int KIND_W  = 3;
   localparam int SYM_W   = 5;
   localparam int START_W = 16;
   localparam int LEN_W   = 16;
   localparam int NUM_W   = 32;
   localparam int CHAR_W  = 8;

   // result queue depth, room for two results is needed per byte
   localparam int RQ_DEPTH = 4;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_RESERVED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_IDENT    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NUMBER   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_END      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_INVALID  = 3'd4;

   // symbol codes
   localparam logic [SYM_W-1:0] SYM_NONE       = 5'd0;
   localparam logic [SYM_W-1:0] SYM_OP_BASE    = 5'd5;
   localparam logic [SYM_W-1:0] SYM_PUNCT_BASE = 5'd9;
   localparam logic [SYM_W-1:0] SYM_LESS       = 5'd16;
   localparam logic [SYM_W-1:0] SYM_GREATER    = 5'd17;
   localparam logic [SYM_W-1:0] SYM_ASSIGN     = 5'd19;

   // pending operator codes
   localparam logic [1:0] OP_ASSIGN  = 2'd0;
   localparam logic [1:0] OP_BANG    = 2'd1;
   localparam logic [1:0] OP_LESS    = 2'd2;
   localparam logic [1:0] OP_GREATER = 2'd3;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LT    = 8'h3c;
   localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3d;
   localparam logic [CHAR_W-1:0] CH_GT    = 8'h3e;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
   localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5f;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;

   // single character punctuators in symbol order
   localparam int PUNCT_COUNT = 14;
   localparam logic [CHAR_W-1:0] PUNCT_CHARS [PUNCT_COUNT] = '{
      8'h2b, 8'h2d, 8'h2a, 8'h26, 8'h2f, 8'h28, 8'h29,
      8'h3c, 8'h3e, 8'h3b, 8'h3d, 8'h7b, 8'h7d, 8'h2c
   };

   // keyword table: if, else, return, while, for
   localparam int KW_COUNT   = 5;
   localparam int KW_MAX_LEN = 6;
   localparam logic [CHAR_W-1:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00},
      '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},
      '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00},
      '{8'h66, 8'h6f, 8'h72, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd6, 3'd5, 3'd3};

   // one result record
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SYM_W-1:0]   sym;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
      logic [NUM_W-1:0]   value;
      logic               last;
   } token_type;

   // queue status toward the scanner and the result port
   typedef struct packed {
      logic valid;
      logic room;
   } rq_status_type;

   // drop keyword candidates that do not match c at offset run
   function automatic logic [KW_COUNT-1:0] kw_narrow(
      input logic [KW_COUNT-1:0] cand,
      input logic [LEN_W-1:0]    run,
      input logic [CHAR_W-1:0]   c
   );
      logic [KW_COUNT-1:0] keep;
      keep = cand;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (!(run < LEN_W'(KW_LEN[i]) && KW_TEXT[i][run[2:0]] == c)) begin
            keep[i] = 1'b0;
         end
      end
      return keep;
   endfunction

   // punctuator lookup: found flag over a 4-bit index
   function automatic logic [4:0] punct_find(input logic [CHAR_W-1:0] c);
      logic [4:0] hit;
      hit = '0;
      for (int i = 0; i < PUNCT_COUNT; i++) begin
         if (!hit[4] && PUNCT_CHARS[i] == c) begin
            hit = {1'b1, 4'(i)};
         end
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/csl_rsp_queue.sv]
`default_nettype none
module csl_rsp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [1:0]             push_cnt,
   input  wire csl_pkg::token_type     push_rec0,
   input  wire csl_pkg::token_type     push_rec1,
   input  wire logic                   pop,
   output csl_pkg::token_type          head_rec,
   output csl_pkg::rq_status_type      status
);
   import csl_pkg::*;

   localparam int AW = $clog2(RQ_DEPTH);
   localparam int CW = AW + 1;

   token_type         mem_ff [RQ_DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_pop;
   logic [AW-1:0]     wr_next;

   assign do_pop  = pop && (count_ff != '0);
   assign wr_next = wr_ptr_ff + AW'(1);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(push_cnt);
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push_cnt) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // record storage, up to two writes per cycle
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_rec0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_next] <= push_rec1;
      end
   end

   assign head_rec     = mem_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.room  = (count_ff <= CW'(RQ_DEPTH - 2));

endmodule
`default_nettype wire

[hw/rtl/c_subset_lexer.sv]
// Tokenizer for a small C subset, one source byte per transaction.
// Input channel req_*: req_tdata[7:0] is the source byte; a zero byte ends
// the text, flushes any open token, gives an end token and restarts the
// offset count at zero.
// Result channel rsp_*: one token per transaction, rsp_tlast marks the last
// token caused by one input byte (a byte causes zero, one or two tokens).
// A byte is classified and the scanner state updated in the cycle it is
// accepted; its tokens are written into a four-entry result queue and show
// on the result port in order, behind any tokens still queued. Identifiers
// and numbers complete only when the byte after them arrives.
// Throughput is one byte per cycle; req_tready stays high while the queue
// has room for two tokens, so it drops only when the receiver stalls or
// bytes produce two tokens faster than they are drained (one token out per
// cycle at most).
// Reset (synchronous, active high) empties the queue and returns the scanner
// to idle at offset zero. After an invalid byte no token is given until the
// zero byte.
`default_nettype none
module c_subset_lexer #(
   parameter int POSITION_WIDTH = csl_pkg::DEF_POSITION_WIDTH,
   parameter int VALUE_WIDTH    = csl_pkg::DEF_VALUE_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [2:0] token_kind, [7:3] symbol_code,
                                         // [23:8] start_pos, [39:24] token_length,
                                         // [71:40] number_value
   output logic             rsp_tlast    // last_of_item
);
   import csl_pkg::*;

   localparam int PW = POSITION_WIDTH;
   localparam int VW = VALUE_WIDTH;
   localparam logic [PW-1:0]    POS_MAX = {PW{1'b1}};
   localparam logic [VW-1:0]    VAL_MAX = {VW{1'b1}};
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_IDENT   = 5'b00010,
      MODE_NUMBER  = 5'b00100,
      MODE_PENDING = 5'b01000,
      MODE_ERROR   = 5'b10000
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [PW-1:0]         start_ff, start_in;
   logic [LEN_W-1:0]      run_ff, run_in;
   logic [VW-1:0]         acc_ff, acc_in;
   logic [KW_COUNT-1:0]   cand_ff, cand_in;
   logic [1:0]            op_ff, op_in;

   logic                  accept;
   logic [CHAR_W-1:0]     c;
   logic                  is_lower, is_digit, is_upper, is_space;
   logic [3:0]            dig;
   logic [4:0]            punct;
   logic [LEN_W-1:0]      run_inc;
   logic [VW+3:0]         acc_prod;
   logic [VW-1:0]         acc_next;
   logic                  kw_hit;
   logic [SYM_W-1:0]      kw_sym;

   logic                  a_valid, b_valid, do_idle, adv;
   token_type             a_rec, b_rec;
   logic [1:0]            push_cnt;
   token_type             push_rec0, push_rec1;
   token_type             head_rec;
   rq_status_type         q_status;

   assign accept = req_tvalid && req_tready;
   assign c      = req_tdata;

   // byte classes
   assign is_lower = (c >= CH_LA) && (c <= CH_LZ);
   assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_upper = (c >= CH_UA) && (c <= CH_UZ);
   assign is_space = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
   assign dig      = c[3:0];
   assign punct    = punct_find(c);
   assign run_inc  = (run_ff != LEN_MAX) ? run_ff + LEN_W'(1) : run_ff;

   // saturating decimal accumulate, times ten as two shifts
   always_comb begin
      acc_prod = ((VW+4)'(acc_ff) << 3) + ((VW+4)'(acc_ff) << 1) + (VW+4)'(dig);
      acc_next = (acc_prod[VW+3:VW] != 4'd0) ? VAL_MAX : acc_prod[VW-1:0];
   end

   // keyword match for the closing identifier
   always_comb begin
      kw_hit = 1'b0;
      kw_sym = SYM_NONE;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (cand_ff[i] && run_ff == LEN_W'(KW_LEN[i])) begin
            kw_hit = 1'b1;
            kw_sym = SYM_W'(i);
         end
      end
   end

   // scanner next state and up to two tokens
   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      run_in   = run_ff;
      acc_in   = acc_ff;
      cand_in  = cand_ff;
      op_in    = op_ff;
      a_valid  = 1'b0;
      b_valid  = 1'b0;
      a_rec    = '0;
      b_rec    = '0;
      do_idle  = 1'b0;
      adv      = 1'b0;

      // close or extend the open token
      unique case (mode_ff)
         MODE_IDLE: begin
            do_idle = 1'b1;
         end
         MODE_ERROR: begin
            if (c == CH_NUL) begin
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_lower || is_digit) begin
               cand_in = kw_narrow(cand_ff, run_ff, c);
               run_in  = run_inc;
               adv     = 1'b1;
            end else begin
               a_valid     = 1'b1;
               a_rec.start = START_W'(start_ff);
               a_rec.len   = run_ff;
               if (kw_hit && !is_upper && c != CH_UNDER) begin
                  a_rec.kind = KIND_RESERVED;
                  a_rec.sym  = kw_sym;
               end else begin
                  a_rec.kind = KIND_IDENT;
               end
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit) begin
               acc_in = acc_next;
               run_in = run_inc;
               adv    = 1'b1;
            end else begin
               a_valid     = 1'b1;
               a_rec.kind  = KIND_NUMBER;
               a_rec.start = START_W'(start_ff);
               a_rec.len   = run_ff;
               a_rec.value = NUM_W'(acc_ff);
               mode_in     = MODE_IDLE;
               do_idle     = 1'b1;
            end
         end
         MODE_PENDING: begin
            mode_in     = MODE_IDLE;
            a_valid     = 1'b1;
            a_rec.start = START_W'(start_ff);
            a_rec.len   = LEN_W'(1);
            if (c == CH_EQ) begin
               a_rec.kind = KIND_RESERVED;
               a_rec.sym  = SYM_OP_BASE + SYM_W'(op_ff);
               a_rec.len  = LEN_W'(2);
               adv        = 1'b1;
            end else if (op_ff == OP_BANG) begin
               a_rec.kind = KIND_INVALID;
               if (c != CH_NUL) begin
                  mode_in = MODE_ERROR;
                  adv     = 1'b1;
               end else begin
                  do_idle = 1'b1;
               end
            end else begin
               a_rec.kind = KIND_RESERVED;
               a_rec.sym  = (op_ff == OP_ASSIGN) ? SYM_ASSIGN :
                            ((op_ff == OP_LESS) ? SYM_LESS : SYM_GREATER);
               do_idle    = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            do_idle = 1'b1;
         end
      endcase

      // handle the byte from idle
      if (do_idle) begin
         b_rec.start = START_W'(pos_ff);
         if (c == CH_NUL) begin
            b_valid  = 1'b1;
            b_rec.kind = KIND_END;
            mode_in  = MODE_IDLE;
            start_in = '0;
            run_in   = '0;
            acc_in   = '0;
            cand_in  = '1;
            op_in    = OP_ASSIGN;
         end else begin
            adv = 1'b1;
            if (is_space) begin
               // skipped
            end else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
               mode_in  = MODE_PENDING;
               start_in = pos_ff;
               op_in    = (c == CH_EQ) ? OP_ASSIGN :
                          ((c == CH_BANG) ? OP_BANG :
                          ((c == CH_LT) ? OP_LESS : OP_GREATER));
            end else if (punct[4]) begin
               b_valid    = 1'b1;
               b_rec.kind = KIND_RESERVED;
               b_rec.sym  = SYM_PUNCT_BASE + SYM_W'(punct[3:0]);
               b_rec.len  = LEN_W'(1);
            end else if (is_lower) begin
               mode_in  = MODE_IDENT;
               start_in = pos_ff;
               cand_in  = kw_narrow('1, '0, c);
               run_in   = LEN_W'(1);
            end else if (is_digit) begin
               mode_in  = MODE_NUMBER;
               start_in = pos_ff;
               run_in   = LEN_W'(1);
               acc_in   = VW'(dig);
            end else begin
               b_valid    = 1'b1;
               b_rec.kind = KIND_INVALID;
               b_rec.len  = LEN_W'(1);
               mode_in    = MODE_ERROR;
            end
         end
      end

      // offset of the next byte
      if (do_idle && c == CH_NUL) begin
         pos_in = '0;
      end else if (adv && pos_ff != POS_MAX) begin
         pos_in = pos_ff + PW'(1);
      end
   end

   // pack tokens for the queue, last flag on the final one
   always_comb begin
      push_cnt  = 2'd0;
      push_rec0 = a_valid ? a_rec : b_rec;
      push_rec1 = b_rec;
      push_rec0.last = 1'b0;
      push_rec1.last = 1'b1;
      if (accept) begin
         if (a_valid && b_valid) begin
            push_cnt = 2'd2;
         end else if (a_valid || b_valid) begin
            push_cnt       = 2'd1;
            push_rec0.last = 1'b1;
         end
      end
   end

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         run_ff   <= '0;
         acc_ff   <= '0;
         cand_ff  <= '1;
         op_ff    <= OP_ASSIGN;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         run_ff   <= run_in;
         acc_ff   <= acc_in;
         cand_ff  <= cand_in;
         op_ff    <= op_in;
      end
   end

   // result queue between scanner and output port
   csl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_rec0 (push_rec0),
      .push_rec1 (push_rec1),
      .pop       (rsp_tready),
      .head_rec  (head_rec),
      .status    (q_status)
   );

   assign req_tready = q_status.room;
   assign rsp_tvalid = q_status.valid;
   assign rsp_tdata  = {head_rec.value, head_rec.len, head_rec.start,
                        head_rec.sym, head_rec.kind};
   assign rsp_tlast  = head_rec.last;

endmodule
`default_nettype wire

[test/tb_c_subset_lexer.sv]
`timescale 1ns / 100ps
module tb_c_subset_lexer;
   import csl_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_BYTES  = 1400;
   localparam int LONG_RUN      = 150;
   localparam logic [START_W-1:0] POS_MAX = '1;
   localparam logic [LEN_W-1:0]   LEN_MAX = '1;
   localparam longint unsigned    VALUE_MAX = 64'h0000_0000_FFFF_FFFF;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_PENDING, SCAN_ERROR
   } scan_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] char_code
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // [2:0] kind, [7:3] symbol, [23:8] start,
                                   // [39:24] length, [71:40] value
   logic        rsp_tlast;         // last_of_item

   // source bytes waiting to be sent and tokens waiting to come out
   logic [CHAR_W-1:0] byte_q [$];
   token_type         token_q [$];

   // handshake bookkeeping
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int   send_gap  = 0;
   int   rsp_hold  = 0;
   logic tx_quiet  = 1'b0;
   logic rx_quiet  = 1'b0;
   int   idle_cycles = 0;
   int   errors = 0;

   // scanner state of the predictor
   scan_state_type     scan_state = SCAN_IDLE;
   logic [START_W-1:0] cur_pos   = '0;
   logic [START_W-1:0] tok_start = '0;
   logic [LEN_W-1:0]   run_len   = '0;
   logic [NUM_W-1:0]   num_acc   = '0;
   logic [KW_COUNT-1:0] kw_cand  = '1;
   logic [1:0]         pend_op   = OP_ASSIGN;

   string keyword_text [KW_COUNT] = '{"if", "else", "return", "while", "for"};
   string op_text [4] = '{"==", "!=", "<=", ">="};

   c_subset_lexer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // keywords still possible after byte c lands at offset run
   function automatic logic [KW_COUNT-1:0] keep_keywords(
      input logic [KW_COUNT-1:0] cand,
      input logic [LEN_W-1:0]    run,
      input logic [CHAR_W-1:0]   c
   );
      logic [KW_COUNT-1:0] keep;
      int r;
      keep = cand;
      r = run;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (r >= KW_LEN[i]) keep[i] = 1'b0;
         else if (KW_TEXT[i][r] != c) keep[i] = 1'b0;
      end
      return keep;
   endfunction

   task automatic emit_token(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                             input logic [START_W-1:0] start, input logic [LEN_W-1:0] len,
                             input logic [NUM_W-1:0] value);
      token_type t;
      t.kind  = kind;
      t.sym   = sym;
      t.start = start;
      t.len   = len;
      t.value = value;
      t.last  = 1'b0;
      token_q.push_back(t);
   endtask

   // advance the scanner by one byte and queue the tokens it completes
   task automatic lex_byte(input logic [CHAR_W-1:0] c);
      logic lower, digit, consumed;
      logic [KIND_W-1:0] kind;
      logic [SYM_W-1:0]  sym;
      longint unsigned d;
      int prior_size, p;
      token_type t;
      prior_size = token_q.size();
      lower    = c >= CH_LA && c <= CH_LZ;
      digit    = c >= CH_ZERO && c <= CH_NINE;
      consumed = 1'b0;

      // close or extend the open token
      case (scan_state)
         SCAN_ERROR: begin
            if (c != CH_NUL) return;
            scan_state = SCAN_IDLE;
         end
         SCAN_IDENT: begin
            if (lower || digit) begin
               kw_cand = keep_keywords(kw_cand, run_len, c);
               if (run_len != LEN_MAX) run_len++;
               consumed = 1'b1;
            end else begin
               kind = KIND_IDENT;
               sym  = SYM_NONE;
               if (!(c >= CH_UA && c <= CH_UZ) && c != CH_UNDER) begin
                  for (int i = 0; i < KW_COUNT; i++) begin
                     if (kw_cand[i] && run_len == LEN_W'(KW_LEN[i])) begin
                        kind = KIND_RESERVED;
                        sym  = SYM_W'(i);
                     end
                  end
               end
               emit_token(kind, sym, tok_start, run_len, '0);
               scan_state = SCAN_IDLE;
            end
         end
         SCAN_NUMBER: begin
            if (digit) begin
               d = c - CH_ZERO;
               if (longint'(num_acc) > (VALUE_MAX - d) / 10) num_acc = '1;
               else num_acc = num_acc * 32'd10 + NUM_W'(d);
               if (run_len != LEN_MAX) run_len++;
               consumed = 1'b1;
            end else begin
               emit_token(KIND_NUMBER, SYM_NONE, tok_start, run_len, num_acc);
               scan_state = SCAN_IDLE;
            end
         end
         SCAN_PENDING: begin
            scan_state = SCAN_IDLE;
            if (c == CH_EQ) begin
               emit_token(KIND_RESERVED, SYM_OP_BASE + SYM_W'(pend_op), tok_start,
                          LEN_W'(2), '0);
               consumed = 1'b1;
            end else if (pend_op == OP_BANG) begin
               // lone bang: the byte after it is swallowed unless it ends the text
               emit_token(KIND_INVALID, SYM_NONE, tok_start, LEN_W'(1), '0);
               if (c != CH_NUL) begin
                  scan_state = SCAN_ERROR;
                  consumed   = 1'b1;
               end
            end else begin
               sym = pend_op == OP_ASSIGN ? SYM_ASSIGN :
                     (pend_op == OP_LESS ? SYM_LESS : SYM_GREATER);
               emit_token(KIND_RESERVED, sym, tok_start, LEN_W'(1), '0);
            end
         end
         default: ;
      endcase

      if (!consumed && c == CH_NUL) begin
         // end of text restarts the offset count
         emit_token(KIND_END, SYM_NONE, cur_pos, LEN_W'(0), '0);
         scan_state = SCAN_IDLE;
         cur_pos    = '0;
         tok_start  = '0;
         run_len    = '0;
         num_acc    = '0;
         kw_cand    = '1;
         pend_op    = OP_ASSIGN;
      end else begin
         if (!consumed) begin
            p = -1;
            for (int i = PUNCT_COUNT - 1; i >= 0; i--) begin
               if (PUNCT_CHARS[i] == c) p = i;
            end
            if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
               // whitespace
            end else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
               scan_state = SCAN_PENDING;
               tok_start  = cur_pos;
               pend_op    = c == CH_EQ ? OP_ASSIGN :
                            (c == CH_BANG ? OP_BANG : (c == CH_LT ? OP_LESS : OP_GREATER));
            end else if (p >= 0) begin
               emit_token(KIND_RESERVED, SYM_PUNCT_BASE + SYM_W'(p), cur_pos,
                          LEN_W'(1), '0);
            end else if (lower) begin
               scan_state = SCAN_IDENT;
               tok_start  = cur_pos;
               kw_cand    = keep_keywords('1, '0, c);
               run_len    = LEN_W'(1);
            end else if (digit) begin
               scan_state = SCAN_NUMBER;
               tok_start  = cur_pos;
               run_len    = LEN_W'(1);
               num_acc    = NUM_W'(c - CH_ZERO);
            end else begin
               emit_token(KIND_INVALID, SYM_NONE, cur_pos, LEN_W'(1), '0);
               scan_state = SCAN_ERROR;
            end
         end
         if (cur_pos != POS_MAX) cur_pos++;
      end

      // flag the final token of this byte
      if (token_q.size() > prior_size) begin
         t = token_q.pop_back();
         t.last = 1'b1;
         token_q.push_back(t);
      end
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   task automatic push_byte(input logic [CHAR_W-1:0] c);
      byte_q.push_back(c);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
   endtask

   // one text of mostly well formed tokens, closed by a zero byte
   task automatic queue_random_text();
      int tokens, n;
      tokens = $urandom_range(1, 14);
      for (int k = 0; k < tokens; k++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
               push_text(keyword_text[$urandom_range(0, KW_COUNT - 1)]);
               case ($urandom_range(0, 15))
                  0: push_byte(CH_UA + CHAR_W'($urandom_range(0, 25)));
                  1: push_byte(CH_UNDER);
                  2: push_byte(CH_LA + CHAR_W'($urandom_range(0, 25)));
                  3: push_byte(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
                  default: ;
               endcase
            end
            4, 5, 6, 7: begin
               push_byte(CH_LA + CHAR_W'($urandom_range(0, 25)));
               n = $urandom_range(0, 6);
               for (int i = 0; i < n; i++) begin
                  if ($urandom_range(0, 2) == 0) push_byte(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
                  else push_byte(CH_LA + CHAR_W'($urandom_range(0, 25)));
               end
            end
            8, 9, 10: begin
               n = $urandom_range(0, 7) == 0 ? $urandom_range(9, 12) : $urandom_range(1, 4);
               for (int i = 0; i < n; i++) push_byte(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
            end
            11, 12, 13: push_byte(PUNCT_CHARS[$urandom_range(0, PUNCT_COUNT - 1)]);
            14, 15, 16: push_text(op_text[$urandom_range(0, 3)]);
            17: push_byte(CH_TAB + CHAR_W'($urandom_range(0, 4)));
            18: push_byte(CHAR_W'($urandom_range(0, 255)));
            default: push_byte(CH_BANG);
         endcase
         case ($urandom_range(0, 3))
            0, 1: push_byte(CH_SPACE);
            2: push_byte(CH_TAB + CHAR_W'($urandom_range(0, 4)));
            default: ;
         endcase
      end
      push_byte(CH_NUL);
   endtask

   // sender: next byte at the falling edge once the previous one was taken and a random gap has run out
   always @(negedge clock) begin : feed
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (byte_q.size() > 0) begin
            req_tdata  <= byte_q.pop_front();
            req_tvalid <= 1'b1;
            send_gap   <= tx_quiet ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 63) == 0) tx_quiet <= !tx_quiet;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: after each token, drop rsp_tready for a random stall, or none while in quiet mode
   always @(negedge clock) begin : drain
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         w = rsp_taken ? (rx_quiet ? 0 : $urandom_range(0, 9)) : rsp_hold;
         if (rsp_taken && $urandom_range(0, 63) == 0) rx_quiet <= !rx_quiet;
         if (w > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= w - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_hold   <= 0;
         end
      end
   end

   // monitor: predict on accepted bytes, compare accepted tokens
   always @(posedge clock) begin : watch
      token_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) lex_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (token_q.size() == 0) begin
               errors++;
               $display("%0t unexpected token: expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = token_q.pop_front();
               check_field("token_kind", 64'(want.kind), 64'(rsp_tdata[2:0]));
               check_field("symbol_code", 64'(want.sym), 64'(rsp_tdata[7:3]));
               check_field("start_pos", 64'(want.start), 64'(rsp_tdata[23:8]));
               check_field("token_length", 64'(want.len), 64'(rsp_tdata[39:24]));
               check_field("number_value", 64'(want.value), 64'(rsp_tdata[71:40]));
               check_field("last_of_item", 64'(want.last), 64'(rsp_tlast));
            end
         end
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_c_subset_lexer failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int base;

      // directed texts
      push_byte(CH_NUL);
      push_text("while(n!=0){n=n-1;}");
      push_byte(CH_NUL);
      push_text("if a>=b,c<d else return x*y&z/2+for\t==\n");
      push_byte(CH_NUL);
      push_text("iff whilee1 ret fo 12ab");
      for (int c = CH_TAB; c <= CH_CR; c++) push_byte(CHAR_W'(c));
      push_text("x9==y>z<");
      push_byte(CH_NUL);
      push_text("ifA tail");
      push_byte(CH_NUL);
      push_text("else_");
      push_byte(CH_NUL);
      push_text("4294967295 4294967296 99999999999 0<");
      push_byte(CH_NUL);
      push_text("!x y");
      push_byte(CH_NUL);
      push_text("a!");
      push_byte(CH_NUL);
      push_text("x>");
      push_byte(8'hff);
      push_text("q");
      push_byte(CH_NUL);
      push_text("= 7");
      push_byte(8'h80);
      push_byte(CH_NUL);

      // one long identifier
      for (int i = 0; i < LONG_RUN; i++) push_byte(CH_LA);
      push_text(" z9 =");
      push_byte(CH_NUL);

      // random texts
      base = byte_q.size();
      while (byte_q.size() < base + RANDOM_BYTES) queue_random_text();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (byte_q.size() > 0 || req_tvalid || token_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && token_q.size() == 0) begin
         $display("tb_c_subset_lexer passed");
      end else begin
         $display("tb_c_subset_lexer failed");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/csl_pkg.sv
hw/rtl/csl_rsp_queue.sv
hw/rtl/c_subset_lexer.sv
test/tb_c_subset_lexer.sv
